// ===== rtl/btmx_pkg.sv =====
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared types, sizes and codes for the binary trie maximum-XOR block.
// ----------------------------------------------------------------------------
`default_nettype none

package btmx_pkg;

  localparam int KEY_BITS   = 31;
  localparam int NODE_COUNT = 32768;

  localparam int IN_KEY_W = 31;
  localparam int XOR_W    = 31;
  localparam int NODE_W   = $clog2(NODE_COUNT);
  localparam int CNT_W    = $clog2(NODE_COUNT + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int LVL_W    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int ENTRY_W  = 2 * NODE_W;

  typedef logic [KEY_BITS-1:0]         key_t;
  typedef logic [XOR_W-1:0]            xor_t;
  typedef logic [NODE_W-1:0]           node_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [SUM_W-1:0]            sum_t;
  typedef logic [LVL_W-1:0]            lvl_t;
  typedef logic [LVL_W:0]              miss_t;
  typedef logic [1:0][NODE_W-1:0]      entry_t;
  typedef logic [1:0]                  status_t;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    other_hit;
    node_t   nxt;
    entry_t  wr_entry;
  } step_t;

  typedef struct packed {
    logic    valid;
    xor_t    best;
    status_t status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/btmx_ram.sv =====
// ----------------------------------------------------------------------------
// btmx_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/btmx_step.sv =====
// ----------------------------------------------------------------------------
// btmx_step
// One trie level: picks the child to follow and builds the node entry to
// write when a new child link is allocated.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_step (
  input  wire btmx_pkg::entry_t entry,
  input  wire logic             key_bit,
  input  wire logic             query,
  input  wire btmx_pkg::node_t  fresh,
  input  wire logic             merge,
  output btmx_pkg::step_t       st
);

  btmx_pkg::node_t  other;
  btmx_pkg::node_t  same;
  btmx_pkg::entry_t base;

  always_comb begin
    other        = entry[~key_bit];
    same         = entry[key_bit];
    st.other_hit = query && (other != '0);
    st.nxt       = st.other_hit ? other : same;
    base         = merge ? entry : '0;
    base[key_bit] = fresh;
    st.wr_entry  = base;
  end

endmodule

`default_nettype wire

// ===== rtl/btmx_seq.sv =====
// ----------------------------------------------------------------------------
// btmx_seq
// Sequencer that walks the trie one level per cycle, checks for room and
// allocates the missing part of an insert path one node per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_seq (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_kind,
  input  wire logic [btmx_pkg::IN_KEY_W-1:0] in_key,
  output logic                        rd_en,
  output btmx_pkg::node_t             rd_addr,
  input  wire btmx_pkg::entry_t       rd_data,
  output logic                        wr_en,
  output btmx_pkg::node_t             wr_addr,
  output btmx_pkg::entry_t            wr_data,
  output btmx_pkg::result_t           res,
  input  wire logic                   out_free
);

  btmx_pkg::state_t  state_r, state_nxt;
  btmx_pkg::cnt_t    used_r, used_nxt;
  logic              holds_r, holds_nxt;

  logic              kind_r, kind_nxt;
  btmx_pkg::key_t    key_r, key_nxt;
  btmx_pkg::lvl_t    lvl_r, lvl_nxt;
  btmx_pkg::node_t   node_r, node_nxt;
  btmx_pkg::key_t    best_r, best_nxt;
  btmx_pkg::status_t status_r, status_nxt;
  btmx_pkg::entry_t  ent_r, ent_nxt;
  logic              first_r, first_nxt;

  btmx_pkg::entry_t  step_entry;
  btmx_pkg::node_t   fresh;
  btmx_pkg::step_t   st;
  logic              accept;
  logic              full;

  assign in_stall = (state_r != btmx_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fresh    = btmx_pkg::node_t'(used_r);
  assign full     = (btmx_pkg::sum_t'(used_r) + btmx_pkg::sum_t'(btmx_pkg::miss_t'(lvl_r) + 1'b1))
                    > btmx_pkg::sum_t'(btmx_pkg::NODE_COUNT);

  always_comb begin
    if (state_r == btmx_pkg::S_WALK) begin
      step_entry = holds_r ? rd_data : '0;
    end else begin
      step_entry = ent_r;
    end
  end

  btmx_step u_step (
    .entry   (step_entry),
    .key_bit (key_r[lvl_r]),
    .query   (kind_r == btmx_pkg::KIND_QUERY),
    .fresh   (fresh),
    .merge   (first_r),
    .st      (st)
  );

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    holds_nxt  = holds_r;
    kind_nxt   = kind_r;
    key_nxt    = key_r;
    lvl_nxt    = lvl_r;
    node_nxt   = node_r;
    best_nxt   = best_r;
    status_nxt = status_r;
    ent_nxt    = ent_r;
    first_nxt  = first_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = node_r;
    wr_data    = st.wr_entry;
    res.valid  = 1'b0;
    res.best   = btmx_pkg::xor_t'(best_r);
    res.status = status_r;

    unique case (state_r)
      btmx_pkg::S_IDLE: begin
        if (accept) begin
          kind_nxt   = in_kind;
          key_nxt    = btmx_pkg::key_t'(in_key);
          lvl_nxt    = btmx_pkg::lvl_t'(btmx_pkg::KEY_BITS - 1);
          node_nxt   = '0;
          best_nxt   = '0;
          status_nxt = btmx_pkg::ST_OK;
          if ((in_kind == btmx_pkg::KIND_QUERY) && !holds_r) begin
            status_nxt = btmx_pkg::ST_EMPTY;
            state_nxt  = btmx_pkg::S_DONE;
          end else begin
            rd_en     = 1'b1;
            state_nxt = btmx_pkg::S_WALK;
          end
        end
      end
      btmx_pkg::S_WALK: begin
        if (kind_r == btmx_pkg::KIND_QUERY) begin
          best_nxt[lvl_r] = st.other_hit;
          if (lvl_r == '0) begin
            state_nxt = btmx_pkg::S_DONE;
          end else begin
            node_nxt = st.nxt;
            lvl_nxt  = lvl_r - 1'b1;
            rd_en    = 1'b1;
            rd_addr  = st.nxt;
          end
        end else if (st.nxt == '0) begin
          ent_nxt = step_entry;
          if (full) begin
            status_nxt = btmx_pkg::ST_FULL;
            state_nxt  = btmx_pkg::S_DONE;
          end else begin
            first_nxt = 1'b1;
            state_nxt = btmx_pkg::S_ALLOC;
          end
        end else if (lvl_r == '0) begin
          state_nxt = btmx_pkg::S_DONE;
        end else begin
          node_nxt = st.nxt;
          lvl_nxt  = lvl_r - 1'b1;
          rd_en    = 1'b1;
          rd_addr  = st.nxt;
        end
      end
      btmx_pkg::S_ALLOC: begin
        wr_en     = 1'b1;
        used_nxt  = used_r + 1'b1;
        node_nxt  = fresh;
        first_nxt = 1'b0;
        if (lvl_r == '0) begin
          holds_nxt = 1'b1;
          state_nxt = btmx_pkg::S_DONE;
        end else begin
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      btmx_pkg::S_DONE: begin
        res.valid = 1'b1;
        if (out_free) begin
          state_nxt = btmx_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = btmx_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btmx_pkg::S_IDLE;
      used_r  <= btmx_pkg::cnt_t'(1);
      holds_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      holds_r <= holds_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    lvl_r    <= lvl_nxt;
    node_r   <= node_nxt;
    best_r   <= best_nxt;
    status_r <= status_nxt;
    ent_r    <= ent_nxt;
    first_r  <= first_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/binary_trie_max_xor.sv =====
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Bitwise trie over keys that answers maximum-XOR queries and takes inserts.
//
//   Channel  Direction  Handshake            Fields
//   in_      input      in_valid / in_stall   in_kind, in_key
//   out_     output     out_valid / out_stall out_best_xor, out_status
//
// A query makes one node store read per level.
// An insert that allocates makes one read per level down to the first
// missing link, then one node store write per new node.
// A refused insert ends as soon as the first missing link is found.
// A query on an empty trie reads no node and goes straight to its result.
// Reset is synchronous; no clearing pass is needed, as the root reads empty
// until the first insert and every other node is written when allocated.
// A stalled result beat is held in the output register while the next input
// beat is accepted and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_max_xor (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_kind,
  input  wire logic [btmx_pkg::IN_KEY_W-1:0] in_key,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [btmx_pkg::XOR_W-1:0]         out_best_xor,
  output logic [1:0]                         out_status
);

  logic               rd_en;
  btmx_pkg::node_t    rd_addr;
  btmx_pkg::entry_t   rd_data;
  logic               wr_en;
  btmx_pkg::node_t    wr_addr;
  btmx_pkg::entry_t   wr_data;
  btmx_pkg::result_t  res;
  logic               out_free;

  logic               out_valid_r;
  btmx_pkg::xor_t     out_best_xor_r;
  btmx_pkg::status_t  out_status_r;

  assign out_free = !out_valid_r || !out_stall;

  btmx_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .in_key   (in_key),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .res      (res),
    .out_free (out_free)
  );

  btmx_ram #(
    .WIDTH (btmx_pkg::ENTRY_W),
    .DEPTH (btmx_pkg::NODE_COUNT)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      out_best_xor_r <= res.best;
      out_status_r   <= res.status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_best_xor = out_best_xor_r;
  assign out_status   = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/btmx_check.sv =====
// ----------------------------------------------------------------------------
// btmx_check
// Port-level checks on the trie block's handshakes and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_check (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [btmx_pkg::XOR_W-1:0]    out_best_xor,
  input wire logic [1:0]                    out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result beat was dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input accepted again before the item finished.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == btmx_pkg::ST_OK) || (out_status == btmx_pkg::ST_EMPTY)
                  || (out_status == btmx_pkg::ST_FULL))
    else $error("Result beat carries an undefined status.");

  a_zero_when_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != btmx_pkg::ST_OK) |-> (out_best_xor == '0))
    else $error("Empty or full status with a non-zero XOR.");

endmodule

bind binary_trie_max_xor btmx_check u_btmx_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_best_xor (out_best_xor),
  .out_status   (out_status)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_trie_max_xor. A short table of directed
// beats is followed by random inserts and queries. Every accepted input beat
// runs through a trie predictor held in the bench. Each result beat is
// compared field by field with the oldest expected result. The input channel
// idles and the output channel stalls at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_BEATS = 930;
  localparam int TAIL_CYCLES  = 80;
  localparam int N_PROBES     = 23;

  typedef struct packed {
    btmx_pkg::xor_t    best;
    btmx_pkg::status_t status;
  } xor_result_t;

  typedef struct packed {
    logic                          kind;
    logic [btmx_pkg::IN_KEY_W-1:0] key;
    logic                          typed;
    btmx_pkg::xor_t                best;
    btmx_pkg::status_t             status;
  } probe_row_t;

  localparam probe_row_t PROBES [N_PROBES] = '{
    '{btmx_pkg::KIND_QUERY,  31'h0000_0000, 1'b1, 31'h0000_0000, btmx_pkg::ST_EMPTY},
    '{btmx_pkg::KIND_QUERY,  31'h7FFF_FFFF, 1'b1, 31'h0000_0000, btmx_pkg::ST_EMPTY},
    '{btmx_pkg::KIND_INSERT, 31'h0000_0000, 1'b1, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h0000_0000, 1'b1, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_INSERT, 31'h0000_0000, 1'b1, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h1234_5678, 1'b1, 31'h1234_5678, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_INSERT, 31'h7FFF_FFFF, 1'b1, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h0000_0000, 1'b1, 31'h7FFF_FFFF, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_INSERT, 31'h7FFF_FFFF, 1'b1, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_INSERT, 31'h5555_5555, 1'b1, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_INSERT, 31'h2AAA_AAAA, 1'b1, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h5555_5555, 1'b0, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h2AAA_AAAA, 1'b0, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_INSERT, 31'h0000_0001, 1'b1, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_INSERT, 31'h4000_0000, 1'b1, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h4000_0001, 1'b0, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h3FFF_FFFE, 1'b0, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h0000_0001, 1'b0, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_INSERT, 31'h3FFF_FFFF, 1'b1, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h0000_0000, 1'b0, 31'h0000_0000, btmx_pkg::ST_OK},
    '{btmx_pkg::KIND_QUERY,  31'h7FFF_FFFE, 1'b0, 31'h0000_0000, btmx_pkg::ST_OK}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_kind;
  logic [btmx_pkg::IN_KEY_W-1:0] in_key;
  logic                          out_valid;
  logic                          out_stall;
  logic [btmx_pkg::XOR_W-1:0]    out_best_xor;
  logic [1:0]                    out_status;

  btmx_pkg::node_t trie_lo [btmx_pkg::NODE_COUNT];
  btmx_pkg::node_t trie_hi [btmx_pkg::NODE_COUNT];
  int unsigned     trie_fill;
  bit              trie_nonempty;

  xor_result_t     pending_results [$];
  btmx_pkg::key_t  stored_keys [$];
  int              err_count;
  int              idle_cycles;
  int              quiet_left;

  binary_trie_max_xor u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_best_xor (out_best_xor),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void trie_clear();
    for (int i = 0; i < btmx_pkg::NODE_COUNT; i++) begin
      trie_lo[i] = '0;
      trie_hi[i] = '0;
    end
    trie_fill     = 1;
    trie_nonempty = 1'b0;
  endfunction

  function automatic btmx_pkg::status_t trie_insert(btmx_pkg::key_t key);
    int              lvl;
    btmx_pkg::node_t node;
    btmx_pkg::node_t nx;
    bit              walking;
    int unsigned     missing;
    node    = '0;
    lvl     = btmx_pkg::KEY_BITS - 1;
    walking = 1'b1;
    while (walking && lvl >= 0) begin
      nx = key[lvl] ? trie_hi[node] : trie_lo[node];
      if (nx == '0) begin
        walking = 1'b0;
      end else begin
        node = nx;
        lvl--;
      end
    end
    missing = lvl + 1;
    if (trie_fill + missing > btmx_pkg::NODE_COUNT) return btmx_pkg::ST_FULL;
    while (lvl >= 0) begin
      if (key[lvl]) trie_hi[node] = btmx_pkg::node_t'(trie_fill);
      else          trie_lo[node] = btmx_pkg::node_t'(trie_fill);
      node = btmx_pkg::node_t'(trie_fill);
      trie_fill++;
      lvl--;
    end
    trie_nonempty = 1'b1;
    return btmx_pkg::ST_OK;
  endfunction

  function automatic btmx_pkg::xor_t trie_best(btmx_pkg::key_t key);
    btmx_pkg::xor_t  best;
    btmx_pkg::node_t node;
    btmx_pkg::node_t other;
    best = '0;
    node = '0;
    for (int lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
      other = key[lvl] ? trie_lo[node] : trie_hi[node];
      if (other != '0) begin
        best[lvl] = 1'b1;
        node      = other;
      end else begin
        node = key[lvl] ? trie_hi[node] : trie_lo[node];
      end
    end
    return best;
  endfunction

  function automatic xor_result_t trie_step(logic kind, btmx_pkg::key_t key);
    xor_result_t res;
    res.best   = '0;
    res.status = btmx_pkg::ST_OK;
    if (kind == btmx_pkg::KIND_INSERT) begin
      res.status = trie_insert(key);
    end else if (!trie_nonempty) begin
      res.status = btmx_pkg::ST_EMPTY;
    end else begin
      res.best = trie_best(key);
    end
    return res;
  endfunction

  function automatic int sender_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(30, 120);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic btmx_pkg::key_t rand_key();
    return btmx_pkg::key_t'($urandom);
  endfunction

  function automatic btmx_pkg::key_t near_key(btmx_pkg::key_t base);
    int             k;
    btmx_pkg::key_t mask;
    k    = $urandom_range(1, btmx_pkg::KEY_BITS);
    mask = btmx_pkg::key_t'((64'd1 << k) - 64'd1);
    return base ^ (rand_key() & mask);
  endfunction

  function automatic btmx_pkg::key_t pick_stored();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  task automatic send_beat(logic kind, btmx_pkg::key_t key, logic typed,
                           btmx_pkg::xor_t best, btmx_pkg::status_t status);
    int          gap;
    xor_result_t res;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    do @(posedge clk); while (in_stall);
    res = trie_step(kind, key);
    if (kind == btmx_pkg::KIND_INSERT && res.status == btmx_pkg::ST_OK)
      stored_keys = {stored_keys, key};
    if (typed) begin
      res.best   = best;
      res.status = status;
    end
    pending_results = {pending_results, res};
  endtask

  task automatic random_beat();
    int             r;
    int             r2;
    btmx_pkg::key_t key;
    logic           kind;
    r    = $urandom_range(0, 99);
    r2   = $urandom_range(0, 99);
    kind = (r < 55) ? btmx_pkg::KIND_INSERT : btmx_pkg::KIND_QUERY;
    if (stored_keys.size() == 0) begin
      key = rand_key();
    end else if (kind == btmx_pkg::KIND_INSERT) begin
      if (r2 < 70)      key = rand_key();
      else if (r2 < 85) key = pick_stored();
      else              key = near_key(pick_stored());
    end else begin
      if (r2 < 50)      key = rand_key();
      else if (r2 < 70) key = pick_stored();
      else if (r2 < 85) key = near_key(pick_stored());
      else              key = ~pick_stored();
    end
    send_beat(kind, key, 1'b0, '0, btmx_pkg::ST_OK);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin : stall_gen
    int r;
    int run;
    bit level;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        level = 1'b0;
        run   = $urandom_range(1, 8);
      end else if (r < 70) begin
        level = 1'b1;
        run   = $urandom_range(1, 3);
      end else if (r < 80) begin
        level = 1'b0;
        run   = $urandom_range(100, 300);
      end else if (r < 95) begin
        level = 1'b1;
        run   = $urandom_range(4, 10);
      end else begin
        level = 1'b1;
        run   = $urandom_range(20, 60);
      end
      out_stall <= level;
      repeat (run) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_out
    xor_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (err_count < 10)
          $display("Unexpected result beat: best_xor %h status %0d", out_best_xor, out_status);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_best_xor !== want.best || out_status !== want.status) begin
          if (err_count < 10)
            $display("Result beat differs: expected best_xor %h status %0d, got %h status %0d",
                     want.best, want.status, out_best_xor, out_status);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timed out with no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_kind     <= btmx_pkg::KIND_INSERT;
    in_key      <= '0;
    err_count   = 0;
    idle_cycles = 0;
    quiet_left  = 0;
    trie_clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_PROBES; i++)
      send_beat(PROBES[i].kind, btmx_pkg::key_t'(PROBES[i].key), PROBES[i].typed,
                PROBES[i].best, PROBES[i].status);
    drain_results();

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      random_beat();
      if (i == RANDOM_BEATS / 2) drain_results();
    end
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
